[hw/rtl/sobt_pkg.sv]
`default_nettype none

package sobt_pkg;

   // Frame geometry limits
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int MIN_SIZE   = 3;

   // Field widths
   localparam int PIX_W   = 8;
   localparam int SIZE_W  = 12;
   localparam int THR_W   = 11;
   localparam int COORD_W = 11;
   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int LINE_W  = 2 * PIX_W;
   localparam int GRAD_W  = PIX_W + 2;
   localparam int MAG_W   = GRAD_W + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2
   } csr_index_type;

   localparam logic [SIZE_W-1:0] WIDTH_RESET     = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET    = SIZE_W'(480);
   localparam logic [THR_W-1:0]  THRESHOLD_RESET = '0;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   edge_value;
      logic [COORD_W-1:0] center_column;
      logic [COORD_W-1:0] center_row;
      logic               frame_done;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0] image_width;
      logic [SIZE_W-1:0] image_height;
      logic [THR_W-1:0]  edge_threshold;
   } cfg_type;

   // 3x3 window indexed [row][column], row 0 oldest, column 0 leftmost
   typedef logic [2:0][2:0][PIX_W-1:0] window_type;

   typedef struct packed {
      window_type         window;
      logic [COORD_W-1:0] center_column;
      logic [COORD_W-1:0] center_row;
      logic               frame_done;
   } work_type;

endpackage

`default_nettype wire

[hw/rtl/sobt_front.sv]
`default_nettype none

module sobt_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire sobt_pkg::req_type         req_data,
   input  wire sobt_pkg::cfg_type         cfg,
   input  wire logic [sobt_pkg::QCNT_W-1:0] q_count,
   output logic                           push_valid,
   output sobt_pkg::work_type             push_data
);

   logic [sobt_pkg::SIZE_W-1:0]  width_eff;
   logic [sobt_pkg::SIZE_W-1:0]  height_eff;
   logic                         accept;

   logic [sobt_pkg::COORD_W-1:0] col_ff, col_in;
   logic [sobt_pkg::COORD_W-1:0] row_ff, row_in;
   logic [sobt_pkg::SIZE_W-1:0]  col_pos;
   logic [sobt_pkg::SIZE_W-1:0]  row_pos;
   logic [sobt_pkg::SIZE_W-1:0]  col_next;
   logic [sobt_pkg::SIZE_W-1:0]  row_next;

   logic                         a_valid_ff;
   logic [sobt_pkg::PIX_W-1:0]   a_pix_ff;
   logic [sobt_pkg::ADDR_W-1:0]  a_addr_ff;
   logic                         a_inner_ff;
   logic [sobt_pkg::COORD_W-1:0] a_ccol_ff;
   logic [sobt_pkg::COORD_W-1:0] a_crow_ff;
   logic                         a_done_ff;

   logic [sobt_pkg::LINE_W-1:0]  line_mem [sobt_pkg::MAX_WIDTH];
   logic [sobt_pkg::LINE_W-1:0]  rd_data_ff;
   logic                         fwd_ff;
   logic [sobt_pkg::LINE_W-1:0]  fwd_data_ff;
   logic [sobt_pkg::LINE_W-1:0]  line_eff;
   logic [sobt_pkg::LINE_W-1:0]  wr_data;
   logic [sobt_pkg::ADDR_W-1:0]  rd_addr;

   sobt_pkg::window_type         win_ff, win_in;

   // Clamp the frame size to the supported range
   always_comb begin
      if (cfg.image_width < sobt_pkg::SIZE_W'(sobt_pkg::MIN_SIZE)) begin
         width_eff = sobt_pkg::SIZE_W'(sobt_pkg::MIN_SIZE);
      end else if (cfg.image_width > sobt_pkg::SIZE_W'(sobt_pkg::MAX_WIDTH)) begin
         width_eff = sobt_pkg::SIZE_W'(sobt_pkg::MAX_WIDTH);
      end else begin
         width_eff = cfg.image_width;
      end
      if (cfg.image_height < sobt_pkg::SIZE_W'(sobt_pkg::MIN_SIZE)) begin
         height_eff = sobt_pkg::SIZE_W'(sobt_pkg::MIN_SIZE);
      end else if (cfg.image_height > sobt_pkg::SIZE_W'(sobt_pkg::MAX_HEIGHT)) begin
         height_eff = sobt_pkg::SIZE_W'(sobt_pkg::MAX_HEIGHT);
      end else begin
         height_eff = cfg.image_height;
      end
   end

   // Take a pixel only when the queue has room for everything in flight
   assign req_ready = ((sobt_pkg::QCNT_W+1)'(q_count) + (sobt_pkg::QCNT_W+1)'(a_valid_ff))
                      < (sobt_pkg::QCNT_W+1)'(sobt_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // Place the incoming pixel and step the raster position
   always_comb begin
      col_pos = req_data.frame_start ? '0 : sobt_pkg::SIZE_W'(col_ff);
      row_pos = req_data.frame_start ? '0 : sobt_pkg::SIZE_W'(row_ff);
      if (col_pos >= width_eff) begin
         col_pos = '0;
         row_pos = row_pos + sobt_pkg::SIZE_W'(1);
      end
      if (row_pos >= height_eff) begin
         row_pos = '0;
      end
      col_next = col_pos + sobt_pkg::SIZE_W'(1);
      row_next = row_pos + sobt_pkg::SIZE_W'(1);
      if (col_next >= width_eff) begin
         col_in = '0;
         row_in = (row_next >= height_eff) ? '0 : row_next[sobt_pkg::COORD_W-1:0];
      end else begin
         col_in = col_next[sobt_pkg::COORD_W-1:0];
         row_in = row_pos[sobt_pkg::COORD_W-1:0];
      end
   end

   assign rd_addr = col_pos[sobt_pkg::ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // Register the accepted pixel and its classification
   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff   <= req_data.pixel;
         a_addr_ff  <= rd_addr;
         a_inner_ff <= (row_pos >= sobt_pkg::SIZE_W'(2)) && (col_pos >= sobt_pkg::SIZE_W'(2));
         a_ccol_ff  <= sobt_pkg::COORD_W'(col_pos - sobt_pkg::SIZE_W'(1));
         a_crow_ff  <= sobt_pkg::COORD_W'(row_pos - sobt_pkg::SIZE_W'(1));
         a_done_ff  <= (row_pos == height_eff - sobt_pkg::SIZE_W'(1)) &&
                       (col_pos == width_eff - sobt_pkg::SIZE_W'(1));
      end
   end

   // Line stores: one entry holds {older, newer} for a column
   assign line_eff = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign wr_data  = {line_eff[sobt_pkg::PIX_W-1:0], a_pix_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff  <= line_mem[rd_addr];
         fwd_ff      <= a_valid_ff && (a_addr_ff == rd_addr);
         fwd_data_ff <= wr_data;
      end
      if (a_valid_ff) begin
         line_mem[a_addr_ff] <= wr_data;
      end
   end

   // Shift the window one column left and load the new column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = line_eff[sobt_pkg::LINE_W-1:sobt_pkg::PIX_W];
      win_in[1][2] = line_eff[sobt_pkg::PIX_W-1:0];
      win_in[2][2] = a_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (a_valid_ff) begin
         win_ff <= win_in;
      end
   end

   // Hand complete interior windows to the queue
   assign push_valid              = a_valid_ff && a_inner_ff;
   assign push_data.window        = win_in;
   assign push_data.center_column = a_ccol_ff;
   assign push_data.center_row    = a_crow_ff;
   assign push_data.frame_done    = a_done_ff;

endmodule

`default_nettype wire

[hw/rtl/sobt_queue.sv]
`default_nettype none

module sobt_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push_valid,
   input  wire sobt_pkg::work_type          push_data,
   input  wire logic                        pop,
   output logic                             head_valid,
   output sobt_pkg::work_type               head_data,
   output logic [sobt_pkg::QCNT_W-1:0]      count
);

   sobt_pkg::work_type              slot_ff [sobt_pkg::QUEUE_DEPTH];
   logic [sobt_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [sobt_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [sobt_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            do_pop;

   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + sobt_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + sobt_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + sobt_pkg::QCNT_W'(1);
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - sobt_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/sobt_back.sv]
`default_nettype none

module sobt_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [sobt_pkg::THR_W-1:0]  edge_threshold,
   input  wire logic                        head_valid,
   input  wire sobt_pkg::work_type          head_data,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output sobt_pkg::rsp_type                rsp_data
);

   sobt_pkg::window_type          w;
   logic [sobt_pkg::GRAD_W-1:0]   x_pos, x_neg, y_pos, y_neg;
   logic [sobt_pkg::GRAD_W-1:0]   ax_in, ay_in;

   logic                          s1_valid_ff;
   logic [sobt_pkg::GRAD_W-1:0]   s1_ax_ff, s1_ay_ff;
   logic [sobt_pkg::COORD_W-1:0]  s1_col_ff, s1_row_ff;
   logic                          s1_done_ff;
   logic                          s1_adv;

   logic [sobt_pkg::MAG_W-1:0]    mag;
   logic [sobt_pkg::PIX_W-1:0]    edge_in;

   logic                          out_valid_ff;
   sobt_pkg::rsp_type             out_data_ff;
   logic                          out_adv;

   // Stall each stage only when the one after it is full and held
   assign out_adv = !out_valid_ff || rsp_ready;
   assign s1_adv  = !s1_valid_ff || out_adv;
   assign pop     = head_valid && s1_adv;

   // Column and row weighted sums of the window, then absolute gradients
   assign w = head_data.window;

   always_comb begin
      x_pos = sobt_pkg::GRAD_W'(w[0][2]) + {1'b0, w[1][2], 1'b0} + sobt_pkg::GRAD_W'(w[2][2]);
      x_neg = sobt_pkg::GRAD_W'(w[0][0]) + {1'b0, w[1][0], 1'b0} + sobt_pkg::GRAD_W'(w[2][0]);
      y_pos = sobt_pkg::GRAD_W'(w[2][0]) + {1'b0, w[2][1], 1'b0} + sobt_pkg::GRAD_W'(w[2][2]);
      y_neg = sobt_pkg::GRAD_W'(w[0][0]) + {1'b0, w[0][1], 1'b0} + sobt_pkg::GRAD_W'(w[0][2]);
      ax_in = (x_pos >= x_neg) ? x_pos - x_neg : x_neg - x_pos;
      ay_in = (y_pos >= y_neg) ? y_pos - y_neg : y_neg - y_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ax_ff   <= ax_in;
         s1_ay_ff   <= ay_in;
         s1_col_ff  <= head_data.center_column;
         s1_row_ff  <= head_data.center_row;
         s1_done_ff <= head_data.frame_done;
      end
   end

   // L1 magnitude, threshold and saturate
   always_comb begin
      mag = sobt_pkg::MAG_W'(s1_ax_ff) + sobt_pkg::MAG_W'(s1_ay_ff);
      if (mag < edge_threshold) begin
         edge_in = '0;
      end else if (mag > sobt_pkg::MAG_W'(sobt_pkg::PIX_MAX)) begin
         edge_in = sobt_pkg::PIX_MAX;
      end else begin
         edge_in = mag[sobt_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_valid_ff) begin
         out_data_ff.edge_value    <= edge_in;
         out_data_ff.center_column <= s1_col_ff;
         out_data_ff.center_row    <= s1_row_ff;
         out_data_ff.frame_done    <= s1_done_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

[hw/rtl/sobel_edge_threshold_core.sv]
`default_nettype none

// Channel   Direction  Ports                           Transfer
// pixel in  input      req_valid, req_ready, req_data  valid && ready at clock edge
// edge out  output     rsp_valid, rsp_ready, rsp_data  valid && ready at clock edge
// csr       input      csr_write, csr_index, csr_wdata write when csr_write is high
//
// One pixel per cycle is accepted while req_ready is high; rsp_valid rises once the pixel that completes
// an interior window has passed the line-store read and window shift, the queue, gradients and magnitude.
// The rate is set by the line-store RAM, one read and one write per cycle.
// A four-entry queue decouples pixel intake from the gradient pipeline; intake stops
// only when rsp_ready is held low long enough that queued entries plus the pixel in flight reach its depth.
// Reset is synchronous; line stores are not cleared and need no clearing pass.

module sobel_edge_threshold_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire sobt_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output sobt_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_write,
   input  wire logic [sobt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sobt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   sobt_pkg::cfg_type                 cfg_ff;
   logic                              push_valid;
   sobt_pkg::work_type                push_data;
   logic                              head_valid;
   sobt_pkg::work_type                head_data;
   logic                              pop;
   logic [sobt_pkg::QCNT_W-1:0]       q_count;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width    <= sobt_pkg::WIDTH_RESET;
         cfg_ff.image_height   <= sobt_pkg::HEIGHT_RESET;
         cfg_ff.edge_threshold <= sobt_pkg::THRESHOLD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sobt_pkg::CSR_IMAGE_WIDTH: begin
               cfg_ff.image_width <= csr_wdata;
            end
            sobt_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_ff.image_height <= csr_wdata;
            end
            sobt_pkg::CSR_EDGE_THRESHOLD: begin
               cfg_ff.edge_threshold <= csr_wdata[sobt_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   sobt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .q_count    (q_count),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   sobt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (q_count)
   );

   sobt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .edge_threshold (cfg_ff.edge_threshold),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule

`default_nettype wire

[hw/rtl/sobt_checker.sv]
`default_nettype none

module sobt_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire sobt_pkg::rsp_type rsp_data
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   // Center of an interior window never sits on the first row or column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.center_column != '0 && rsp_data.center_row != '0))
      else $error("result on a border pixel");

   // Drop all results out of reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present right after reset");

endmodule

bind sobel_edge_threshold_core sobt_checker u_sobt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[bench/sobel_edge_threshold_core_tb.sv]
`timescale 1ns / 100ps

module sobel_edge_threshold_core_tb;
   import sobt_pkg::*;

   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DIRECTED_ROWS    = 20;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
      logic             has_known_rsp;
      rsp_type          known_rsp;
   } directed_row_type;

   localparam rsp_type NO_RSP = '0;
   localparam rsp_type FULL_EDGE_AT_CENTER = '{
      edge_value: PIX_MAX, center_column: 11'd1, center_row: 11'd1, frame_done: 1'b1};

   // 3x3 frames: flat top over bright bottom row, a broken start, bright left column
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'd0,   1'b1, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd255, 1'b0, 1'b0, NO_RSP},
      '{8'd255, 1'b0, 1'b0, NO_RSP},
      '{8'd255, 1'b0, 1'b1, FULL_EDGE_AT_CENTER},
      '{8'd77,  1'b0, 1'b0, NO_RSP},
      '{8'd200, 1'b0, 1'b0, NO_RSP},
      '{8'd255, 1'b1, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd255, 1'b0, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd255, 1'b0, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b0, NO_RSP},
      '{8'd0,   1'b0, 1'b1, FULL_EDGE_AT_CENTER}
   };

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Edge predictor state
   logic [SIZE_W-1:0] model_width = WIDTH_RESET;
   logic [SIZE_W-1:0] model_height = HEIGHT_RESET;
   logic [THR_W-1:0]  model_threshold = THRESHOLD_RESET;
   logic [PIX_W-1:0]  upper_line [MAX_WIDTH];
   logic [PIX_W-1:0]  prior_line [MAX_WIDTH];
   int                win [3][3] = '{default: 0};
   int                next_col = 0;
   int                next_row = 0;

   rsp_type pending_edges [$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_request = 1'b0;

   sobel_edge_threshold_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int clamp_size(input logic [SIZE_W-1:0] raw, input int top);
      if (raw < MIN_SIZE) return MIN_SIZE;
      if (raw > top) return top;
      return int'(raw);
   endfunction

   // Advance the predictor by one pixel; return 1 when a full window yields an edge
   function automatic bit predict_edge(input logic [PIX_W-1:0] pix, input logic fs,
                                       output rsp_type res);
      int w, h, c, r, gx, gy, mag, i;
      w = clamp_size(model_width, MAX_WIDTH);
      h = clamp_size(model_height, MAX_HEIGHT);
      res = '0;
      if (fs) begin
         next_col = 0;
         next_row = 0;
      end
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      c = next_col;
      r = next_row;

      // shift the window left and load the new column from the line stores
      for (i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = int'(upper_line[c]);
      win[1][2] = int'(prior_line[c]);
      win[2][2] = int'(pix);
      upper_line[c] = prior_line[c];
      prior_line[c] = pix;

      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
      if (r < 2 || c < 2) return 1'b0;

      gx = win[0][2] + 2 * win[1][2] + win[2][2] - win[0][0] - 2 * win[1][0] - win[2][0];
      gy = win[2][0] + 2 * win[2][1] + win[2][2] - win[0][0] - 2 * win[0][1] - win[0][2];
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag >= int'(model_threshold))
         res.edge_value = PIX_W'(mag > int'(PIX_MAX) ? int'(PIX_MAX) : mag);
      res.center_column = COORD_W'(c - 1);
      res.center_row = COORD_W'(r - 1);
      res.frame_done = (r == h - 1) && (c == w - 1);
      return 1'b1;
   endfunction

   // Offer one pixel, hold it until the transfer, then queue its expected edge
   task automatic offer_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                              input logic has_known, input rsp_type known);
      rsp_type predicted;
      bit      produced;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{pixel: pix, frame_start: fs};
      do @(posedge clock); while (!req_ready);
      produced = predict_edge(pix, fs, predicted);
      if (has_known) pending_edges.push_back(known);
      else if (produced) pending_edges.push_back(predicted);
   endtask

   task automatic wait_idle();
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_one(input csr_index_type idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH: model_width = SIZE_W'(value);
         CSR_IMAGE_HEIGHT: model_height = SIZE_W'(value);
         CSR_EDGE_THRESHOLD: model_threshold = THR_W'(value);
         default: ;
      endcase
   endtask

   task automatic write_registers(input int width_raw, input int height_raw, input int thr);
      write_one(CSR_IMAGE_WIDTH, width_raw);
      write_one(CSR_IMAGE_HEIGHT, height_raw);
      write_one(CSR_EDGE_THRESHOLD, thr);
      csr_write <= 1'b0;
   endtask

   // Low-contrast images keep magnitudes near the threshold; extremes show up either way
   function automatic logic [PIX_W-1:0] draw_pixel(input bit smooth, input int base);
      int roll, v;
      roll = $urandom_range(99);
      if (roll < 3) return '0;
      if (roll < 6) return PIX_MAX;
      if (!smooth) return PIX_W'($urandom_range(255));
      v = base + $urandom_range(12) - 6;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return PIX_W'(v);
   endfunction

   task automatic run_phase(input int width_raw, input int height_raw, input int thr,
                            input int item_count, input bit lead_mark, input int mark_pct,
                            input int hold_at);
      bit  smooth;
      int  base, i;
      logic fs;
      wait_idle();
      write_registers(width_raw, height_raw, thr);
      smooth = $urandom_range(1);
      base = $urandom_range(255);
      for (i = 0; i < item_count; i++) begin
         if (i == hold_at) hold_request = 1'b1;
         fs = (i == 0 && lead_mark) || ($urandom_range(99) < mark_pct);
         offer_pixel(draw_pixel(smooth, base), fs, 1'b0, NO_RSP);
      end
      req_valid <= 1'b0;
   endtask

   task automatic run_random_phases(input int item_total);
      int done_items, w_raw, h_raw, thr, n, roll;
      bit lead;
      done_items = 0;
      while (done_items < item_total) begin
         roll = $urandom_range(99);
         if (roll < 5) w_raw = $urandom_range(2);
         else if (roll < 8) w_raw = $urandom_range(1) ? MAX_WIDTH : 4095;
         else w_raw = $urandom_range(16, 3);
         roll = $urandom_range(99);
         if (roll < 5) h_raw = $urandom_range(2);
         else if (roll < 8) h_raw = $urandom_range(4095);
         else h_raw = $urandom_range(8, 3);
         case ($urandom_range(3))
            0: thr = 0;
            1: thr = 2047;
            2: thr = $urandom_range(300);
            default: thr = $urandom_range(2047);
         endcase
         n = $urandom_range(120, 20);
         // a wider row would read line entries never written, so restart the frame
         lead = (clamp_size(SIZE_W'(w_raw), MAX_WIDTH) > clamp_size(model_width, MAX_WIDTH))
                || $urandom_range(1);
         run_phase(w_raw, h_raw, thr, n, lead, 2, -1);
         done_items += n;
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic compare_field(input string field, input int got, input int want);
      if (got != want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Check each result transfer against the oldest expected edge
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_edges.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %0d at (%0d, %0d)",
                        $time, rsp_data.edge_value, rsp_data.center_column,
                        rsp_data.center_row);
               error_count++;
            end else begin
               want = pending_edges.pop_front();
               compare_field("edge_value", rsp_data.edge_value, want.edge_value);
               compare_field("center_column", rsp_data.center_column, want.center_column);
               compare_field("center_row", rsp_data.center_row, want.center_row);
               compare_field("frame_done", rsp_data.frame_done, want.frame_done);
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver heavily
      send_idle_pct = 14;
      recv_idle_pct = 72;
      write_registers(3, 3, 0);
      for (i = 0; i < DIRECTED_ROWS; i++)
         offer_pixel(directed_rows[i].pixel, directed_rows[i].frame_start,
                     directed_rows[i].has_known_rsp, directed_rows[i].known_rsp);
      req_valid <= 1'b0;

      // sizes below the minimum, threshold above any magnitude
      run_phase(0, 1, 2047, 40, 1'b1, 0, -1);
      // widest row, shortest frame
      run_phase(MAX_WIDTH, 3, 60, 200, 1'b1, 0, -1);
      run_random_phases(250);

      send_idle_pct = 72;
      recv_idle_pct = 14;
      // narrowest row, oversized height clamps to the tallest frame
      run_phase(2, 4095, 1, 200, 1'b1, 0, -1);
      run_random_phases(250);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long result hold-off while pixels keep coming, to back up the intake
      run_phase(3, 200, 0, 150, 1'b1, 0, 20);
      run_random_phases(250);

      wait_idle();
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

[files.f]
hw/rtl/sobt_pkg.sv
hw/rtl/sobt_front.sv
hw/rtl/sobt_queue.sv
hw/rtl/sobt_back.sv
hw/rtl/sobel_edge_threshold_core.sv
hw/rtl/sobt_checker.sv
bench/sobel_edge_threshold_core_tb.sv
